// ===== hdl/bc1_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bc1_pkg: shared types, constants and color helpers
// Holds the queue entry and pixel formats and the RGB565 expansion and
// palette interpolation arithmetic used by the BC1 decoder.
// ----------------------------------------------------------------------------
package bc1_pkg;

    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int COORD_W    = 14;
    localparam int CNT_W      = 12;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 15'd16;
    localparam logic [7:0]            ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0]            ALPHA_CLEAR  = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    // One visible block, ready to be streamed out as pixels.
    typedef struct packed {
        t_rgb [3:0]         pal;
        logic               opaque;
        logic [31:0]        idx;
        logic [COORD_W-1:0] base_x;
        logic [COORD_W-1:0] base_y;
        logic [2:0]         ncol;
        logic [2:0]         nrow;
        logic               last_blk;
    } t_entry;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        t_rgb               rgb;
        logic [7:0]         alpha;
        logic               last_blk;
        logic               last_img;
    } t_pixel;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_fifo_stat;

    // v * 255 / 31 truncated is 8v + floor(7v / 31); the second term steps up
    // at fixed thresholds and fills the low three bits.
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [2:0] k;
        k = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
          + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v == 5'd31);
        return {v, k};
    endfunction

    // v * 255 / 63 truncated is 4v + floor(v / 21) in the low two bits.
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [1:0] k;
        k = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v == 6'd63);
        return {v, k};
    endfunction

    // (2a + b + 1) / 3 via reciprocal multiply; exact for sums below 8192.
    function automatic logic [7:0] third(input logic [7:0] a, input logic [7:0] b);
        logic [9:0]  n;
        logic [21:0] p;
        n = {1'b0, a, 1'b0} + 10'(b) + 10'd1;
        p = 22'(n) * 22'd2731;
        return p[20:13];
    endfunction

    function automatic logic [7:0] mid(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = 9'(a) + 9'(b);
        return s[8:1];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/bc1_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bc1_fifo: block queue
// Short queue of decoded block entries between the front and back parts.
// ----------------------------------------------------------------------------
module bc1_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  bc1_pkg::t_entry      i_entry,
    input  wire logic            i_pop,
    output bc1_pkg::t_entry      o_entry,
    output bc1_pkg::t_fifo_stat  o_stat
);
    import bc1_pkg::*;

    t_entry                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry          = r_mem[r_rd_ptr];
    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.full      = (r_count == FIFO_CNT_W'(FIFO_DEPTH));

endmodule
`default_nettype wire

// ===== hdl/bc1_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bc1_front: block intake and classification
// Accepts compressed blocks, tracks the block position, works out clipping
// and builds the four-entry palette for the queue.
// ----------------------------------------------------------------------------
module bc1_front #(
    parameter int MAX_DIMENSION = 16384
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [63:0]                    i_block_bits,
    input  wire logic [bc1_pkg::CFG_DATA_W-1:0] i_image_width,
    input  wire logic [bc1_pkg::CFG_DATA_W-1:0] i_image_height,
    input  bc1_pkg::t_fifo_stat                 i_fifo_stat,
    output logic                                o_push,
    output bc1_pkg::t_entry                     o_entry
);
    import bc1_pkg::*;

    localparam int DW = $clog2(MAX_DIMENSION + 1);
    localparam int CW = ((DW > CFG_DATA_W) ? DW : CFG_DATA_W) + 1;

    logic               r_valid;
    logic [63:0]        r_bits;
    logic [COORD_W-1:0] r_base_x, r_base_y;
    logic [2:0]         r_ncol, r_nrow;
    logic               r_last_blk;
    logic [CNT_W-1:0]   r_col, n_col;
    logic [CNT_W-1:0]   r_row, n_row;

    logic [CW-1:0]      w_w, w_h, w_bx, w_by;
    logic [CW-1:0]      w_dx, w_dy;
    logic [COORD_W-1:0] w_base_x, w_base_y;
    logic [2:0]         w_ncol, w_nrow;
    logic               w_last_blk;
    logic [CNT_W-1:0]   w_col_inc, w_row_inc;
    logic               w_accept, w_clipped, w_free;
    t_rgb               w_a, w_b;
    logic               w_opaque;

    function automatic logic [CW-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        if (v == '0) begin
            return CW'(1);
        end else if (CW'(v) > CW'(MAX_DIMENSION)) begin
            return CW'(MAX_DIMENSION);
        end
        return CW'(v);
    endfunction

    function automatic logic [2:0] visible(input logic [CW-1:0] lim,
                                           input logic [COORD_W-1:0] base);
        logic [CW-1:0] d;
        d = lim - CW'(base);
        if (lim <= CW'(base)) begin
            return 3'd0;
        end else if (d >= CW'(4)) begin
            return 3'd4;
        end
        return d[2:0];
    endfunction

    // Position and clipping for the block at the current counters.
    always_comb begin
        w_w        = clamp_dim(i_image_width);
        w_h        = clamp_dim(i_image_height);
        w_bx       = (w_w + CW'(3)) >> 2;
        w_by       = (w_h + CW'(3)) >> 2;
        w_base_x   = {r_col, 2'b00};
        w_base_y   = {r_row, 2'b00};
        w_dx       = w_w;
        w_dy       = w_h;
        w_ncol     = visible(w_dx, w_base_x);
        w_nrow     = visible(w_dy, w_base_y);
        w_last_blk = (CW'(r_col) + CW'(1) == w_bx) && (CW'(r_row) + CW'(1) == w_by);
    end

    // Advance the block counters; a column or row at or past its limit wraps.
    always_comb begin
        w_col_inc = r_col + 1'b1;
        w_row_inc = r_row + 1'b1;
        n_col     = r_col;
        n_row     = r_row;
        if (w_accept) begin
            if (CW'(w_col_inc) >= w_bx || w_col_inc == '0) begin
                n_col = '0;
                n_row = (CW'(w_row_inc) >= w_by) ? '0 : w_row_inc;
            end else begin
                n_col = w_col_inc;
            end
        end
    end

    // Drop fully clipped blocks at the stage; push the rest when the queue has room.
    assign w_clipped  = (r_ncol == 3'd0) || (r_nrow == 3'd0);
    assign o_push     = r_valid && !w_clipped && !i_fifo_stat.full;
    assign w_free     = !r_valid || w_clipped || o_push;
    assign o_in_ready = w_free;
    assign w_accept   = i_in_valid && w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_valid <= w_accept || (r_valid && !w_free);
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bits     <= i_block_bits;
            r_base_x   <= w_base_x;
            r_base_y   <= w_base_y;
            r_ncol     <= w_ncol;
            r_nrow     <= w_nrow;
            r_last_blk <= w_last_blk;
        end
    end

    // Palette from the held block.
    always_comb begin
        w_a      = '{r: expand5(r_bits[15:11]), g: expand6(r_bits[10:5]),
                     b: expand5(r_bits[4:0])};
        w_b      = '{r: expand5(r_bits[31:27]), g: expand6(r_bits[26:21]),
                     b: expand5(r_bits[20:16])};
        w_opaque = (r_bits[15:0] > r_bits[31:16]);

        o_entry.pal[0] = w_a;
        o_entry.pal[1] = w_b;
        if (w_opaque) begin
            o_entry.pal[2] = '{r: third(w_a.r, w_b.r), g: third(w_a.g, w_b.g),
                               b: third(w_a.b, w_b.b)};
            o_entry.pal[3] = '{r: third(w_b.r, w_a.r), g: third(w_b.g, w_a.g),
                               b: third(w_b.b, w_a.b)};
        end else begin
            o_entry.pal[2] = '{r: mid(w_a.r, w_b.r), g: mid(w_a.g, w_b.g),
                               b: mid(w_a.b, w_b.b)};
            o_entry.pal[3] = '0;
        end
        o_entry.opaque   = w_opaque;
        o_entry.idx      = r_bits[63:32];
        o_entry.base_x   = r_base_x;
        o_entry.base_y   = r_base_y;
        o_entry.ncol     = r_ncol;
        o_entry.nrow     = r_nrow;
        o_entry.last_blk = r_last_blk;
    end

endmodule
`default_nettype wire

// ===== hdl/bc1_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bc1_back: pixel streamer
// Walks the visible texels of one queued block, one pixel per cycle while
// the output is accepted, into a registered output stage.
// ----------------------------------------------------------------------------
module bc1_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  bc1_pkg::t_entry     i_entry,
    input  bc1_pkg::t_fifo_stat i_fifo_stat,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output bc1_pkg::t_pixel     o_pixel
);
    import bc1_pkg::*;

    logic       r_busy;
    t_entry     r_cur;
    logic [1:0] r_px, n_px;
    logic [1:0] r_py, n_py;
    logic       r_out_valid;
    t_pixel     r_out, n_out;

    logic       w_out_free, w_adv, w_last_x, w_last_y, w_last;
    logic [1:0] w_sel;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_adv      = r_busy && w_out_free;
    assign w_last_x   = ({1'b0, r_px} + 3'd1 == r_cur.ncol);
    assign w_last_y   = ({1'b0, r_py} + 3'd1 == r_cur.nrow);
    assign w_last     = w_last_x && w_last_y;
    assign o_pop      = i_fifo_stat.not_empty && (!r_busy || (w_adv && w_last));

    always_comb begin
        w_sel           = r_cur.idx[{r_py, r_px, 1'b0} +: 2];
        n_out.x         = r_cur.base_x + COORD_W'(r_px);
        n_out.y         = r_cur.base_y + COORD_W'(r_py);
        n_out.rgb       = r_cur.pal[w_sel];
        n_out.alpha     = (w_sel == 2'd3 && !r_cur.opaque) ? ALPHA_CLEAR : ALPHA_OPAQUE;
        n_out.last_blk  = w_last;
        n_out.last_img  = w_last && r_cur.last_blk;
    end

    always_comb begin
        n_px = r_px;
        n_py = r_py;
        if (o_pop) begin
            n_px = '0;
            n_py = '0;
        end else if (w_adv) begin
            if (w_last_x) begin
                n_px = '0;
                n_py = r_py + 1'b1;
            end else begin
                n_px = r_px + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_px        <= '0;
            r_py        <= '0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (w_adv && w_last) begin
                r_busy <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_px <= n_px;
            r_py <= n_py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_entry;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel     = r_out;

endmodule
`default_nettype wire

// ===== hdl/bc1_block_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bc1_block_decoder_top: BC1 texture block decoder
// Decodes 8-byte BC1 blocks in raster block order into clipped RGBA pixels
// with image coordinates.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                    Carries
//  in        input      i_in_valid / o_in_ready      i_block_bits
//  out       output     o_out_valid / i_out_ready    pixel coords, RGBA, last flags
//  cfg       input      i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// Rate: one pixel per cycle while the output is accepted, one per visible
// texel of a block, 16 for an interior block; the back part's pixel walker
// sets the rate. A fully clipped block is dropped in the front stage. A request
// passes the front stage, the queue and the walker's block register to the output register.
// Reset: synchronous, active low; clears the block counters, the queue and all
// valid flags, and sets both image dimensions to 16.
// Stalls: the two-entry queue lets the front keep taking requests while the
// output is held back, and the front stage stalls only when the queue is full.
// ----------------------------------------------------------------------------
module bc1_block_decoder_top #(
    parameter int MAX_DIMENSION = 16384
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // compressed block requests
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [63:0]                    i_block_bits,
    // pixel results
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [bc1_pkg::COORD_W-1:0]         o_pixel_x,
    output logic [bc1_pkg::COORD_W-1:0]         o_pixel_y,
    output logic [7:0]                          o_red,
    output logic [7:0]                          o_green,
    output logic [7:0]                          o_blue,
    output logic [7:0]                          o_alpha,
    output logic                                o_last_in_block,
    output logic                                o_last_in_image,
    // configuration writes
    input  wire logic                           i_cfg_we,
    input  wire logic [bc1_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bc1_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bc1_pkg::*;

    logic [CFG_DATA_W-1:0] r_image_width;
    logic [CFG_DATA_W-1:0] r_image_height;

    t_entry     w_push_entry, w_head_entry;
    t_fifo_stat w_fifo_stat;
    logic       w_push, w_pop;
    t_pixel     w_pixel;

    // Hold the image dimensions; write by register index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= DIM_RESET;
            r_image_height <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default:          r_image_width  <= r_image_width;
            endcase
        end
    end

    // Front: take requests, advance block position, build palette.
    bc1_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_block_bits   (i_block_bits),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_fifo_stat    (w_fifo_stat),
        .o_push         (w_push),
        .o_entry        (w_push_entry)
    );

    // Queue of visible blocks.
    bc1_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head_entry),
        .o_stat  (w_fifo_stat)
    );

    // Back: stream visible texels through the output register.
    bc1_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (w_head_entry),
        .i_fifo_stat (w_fifo_stat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel     (w_pixel)
    );

    assign o_pixel_x       = w_pixel.x;
    assign o_pixel_y       = w_pixel.y;
    assign o_red           = w_pixel.rgb.r;
    assign o_green         = w_pixel.rgb.g;
    assign o_blue          = w_pixel.rgb.b;
    assign o_alpha         = w_pixel.alpha;
    assign o_last_in_block = w_pixel.last_blk;
    assign o_last_in_image = w_pixel.last_img;

    // The image ends only on the last pixel of a block.
    a_last_img_in_blk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_in_image |-> o_last_in_block)
        else $error("last_in_image without last_in_block");

    // Nothing leaves the block in the cycle after reset.
    a_quiet_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    // Pop only a queue that holds an entry.
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_fifo_stat.not_empty)
        else $error("queue popped while empty");

    // Push only into a queue with room.
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_fifo_stat.full)
        else $error("queue pushed while full");

endmodule
`default_nettype wire
